// ===== src/lavm_pkg.sv =====
// Shared constants, types and helpers of the look-at view matrix unit.
// Used by look_at_view_matrix_unit and lavm_chk; depends on nothing else.
`default_nettype none

package lavm_pkg;

	localparam int WORD_WIDTH  = 32;
	localparam int FRAC_BITS   = 16;
	localparam int AXIS_WIDTH  = FRAC_BITS + 2;
	localparam int NORM_BITS   = 30;
	localparam int CROSS_WIDTH = 2 * (NORM_BITS + 1);
	localparam int MAG_WIDTH   = CROSS_WIDTH;
	localparam int LEN_WIDTH   = $clog2(MAG_WIDTH + 1);
	localparam int SQ_WIDTH    = 2 * NORM_BITS + 2;
	localparam int SQ_STEPS    = SQ_WIDTH / 2;
	localparam int ROOT_WIDTH  = SQ_STEPS;
	localparam int REM_WIDTH   = ROOT_WIDTH + 3;
	localparam int NUM_WIDTH   = NORM_BITS + FRAC_BITS + 1;
	localparam int QUO_BITS    = FRAC_BITS + 1;
	localparam int DREM_WIDTH  = ROOT_WIDTH + 1;
	localparam int VP_WIDTH    = 2 * AXIS_WIDTH;
	localparam int TP_WIDTH    = AXIS_WIDTH + WORD_WIDTH;
	localparam int TS_WIDTH    = TP_WIDTH + 2;

	localparam logic [1:0] ROW_U = 2'd0;
	localparam logic [1:0] ROW_V = 2'd1;
	localparam logic [1:0] ROW_W = 2'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DIR = 2'd1,
		ST_PARALLEL = 2'd2
	} status_t;

	typedef logic [MAG_WIDTH-1:0] mag_t;
	typedef logic [NORM_BITS-1:0] nmag_t;
	typedef logic [LEN_WIDTH-1:0] blen_t;
	typedef logic signed [AXIS_WIDTH-1:0] axis_t;

	typedef struct packed {
		logic [2:0][WORD_WIDTH-1:0] pos;
		status_t                    status;
	} side_t;

	function automatic mag_t mag_of(input logic signed [MAG_WIDTH-1:0] x);
		mag_t m;
		m = x[MAG_WIDTH-1] ? mag_t'(-x) : mag_t'(x);
		return m;
	endfunction

	function automatic blen_t bit_len(input mag_t m);
		blen_t n;
		n = '0;
		for (int i = 0; i < MAG_WIDTH; i++) begin
			if (m[i]) n = blen_t'(i + 1);
		end
		return n;
	endfunction

	function automatic nmag_t norm_shift(input mag_t m, input blen_t len);
		mag_t s;
		if (len > blen_t'(NORM_BITS)) begin
			s = m >> (len - blen_t'(NORM_BITS));
		end else begin
			s = m << (blen_t'(NORM_BITS) - len);
		end
		return s[NORM_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/look_at_view_matrix_unit.sv =====
// Look-at view matrix unit: pipelined basis build, normalize, translation, row output.
// Depends on lavm_pkg.
//
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid in_ready opcode pos_* vec_* up_*  | into unit
// out     | out_valid out_ready row_index axis_* translation status last_row | out of unit
//
// After an item is accepted, its rows follow one per cycle while out_ready is high.
// Each item gives three rows on the single output port, so that port sets the sustained item rate.
// The square root (31 stages) and the dividers (17 stages) are one step per stage.
// The whole pipeline holds when the last stage has an item the row register cannot take.
// Reset clears the valid bits and the row index; payload registers, row data included, are not reset.
`default_nettype none

module look_at_view_matrix_unit (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic                                    opcode,
	input  wire logic signed [lavm_pkg::WORD_WIDTH-1:0]  pos_x,
	input  wire logic signed [lavm_pkg::WORD_WIDTH-1:0]  pos_y,
	input  wire logic signed [lavm_pkg::WORD_WIDTH-1:0]  pos_z,
	input  wire logic signed [lavm_pkg::WORD_WIDTH-1:0]  vec_x,
	input  wire logic signed [lavm_pkg::WORD_WIDTH-1:0]  vec_y,
	input  wire logic signed [lavm_pkg::WORD_WIDTH-1:0]  vec_z,
	input  wire logic signed [lavm_pkg::WORD_WIDTH-1:0]  up_x,
	input  wire logic signed [lavm_pkg::WORD_WIDTH-1:0]  up_y,
	input  wire logic signed [lavm_pkg::WORD_WIDTH-1:0]  up_z,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic [1:0]                                   row_index,
	output logic signed [lavm_pkg::AXIS_WIDTH-1:0]       axis_x,
	output logic signed [lavm_pkg::AXIS_WIDTH-1:0]       axis_y,
	output logic signed [lavm_pkg::AXIS_WIDTH-1:0]       axis_z,
	output logic signed [lavm_pkg::WORD_WIDTH-1:0]       translation,
	output logic [1:0]                                   status,
	output logic                                         last_row
);

	localparam int WW   = lavm_pkg::WORD_WIDTH;
	localparam int FB   = lavm_pkg::FRAC_BITS;
	localparam int AW   = lavm_pkg::AXIS_WIDTH;
	localparam int NB   = lavm_pkg::NORM_BITS;
	localparam int CW   = lavm_pkg::CROSS_WIDTH;
	localparam int MGW  = lavm_pkg::MAG_WIDTH;
	localparam int SQW  = lavm_pkg::SQ_WIDTH;
	localparam int SQS  = lavm_pkg::SQ_STEPS;
	localparam int RTW  = lavm_pkg::ROOT_WIDTH;
	localparam int RMW  = lavm_pkg::REM_WIDTH;
	localparam int NUMW = lavm_pkg::NUM_WIDTH;
	localparam int QB   = lavm_pkg::QUO_BITS;
	localparam int DRW  = lavm_pkg::DREM_WIDTH;
	localparam int VPW  = lavm_pkg::VP_WIDTH;
	localparam int TPW  = lavm_pkg::TP_WIDTH;
	localparam int TSW  = lavm_pkg::TS_WIDTH;
	localparam int NST  = 11 + SQS + 1 + QB + 7;
	localparam int I_TP = NST - 2;

	logic adv;
	logic [NST:1] vld_s;
	lavm_pkg::side_t side_s [1:NST];

	logic signed [WW-1:0] pos_a [3];
	logic signed [WW-1:0] vec_a [3];
	logic signed [WW-1:0] up_a [3];

	assign pos_a[0] = pos_x;
	assign pos_a[1] = pos_y;
	assign pos_a[2] = pos_z;
	assign vec_a[0] = vec_x;
	assign vec_a[1] = vec_y;
	assign vec_a[2] = vec_z;
	assign up_a[0]  = up_x;
	assign up_a[1]  = up_y;
	assign up_a[2]  = up_z;

	// front end: direction, prescale of direction and up, cross product, prescale, squares and sums of squares
	logic signed [WW:0]     d_s1 [3];
	logic signed [WW:0]     up_s1 [3];
	lavm_pkg::mag_t         mag2_c [2][3];
	lavm_pkg::mag_t         mag_s2 [2][3];
	logic                   sgn_s2 [2][3];
	lavm_pkg::mag_t         or_s2 [2];
	lavm_pkg::mag_t         mag_s3 [2][3];
	logic                   sgn_s3 [2][3];
	lavm_pkg::blen_t        len_s3 [2];
	lavm_pkg::nmag_t        nm_s4 [2][3];
	logic                   sgn_s4 [2][3];
	logic signed [NB:0]     dsv_c [3];
	logic signed [NB:0]     usv_c [3];
	logic signed [CW-1:0]   prod_s5 [6];
	lavm_pkg::nmag_t        dnm_s5 [3];
	logic                   dsg_s5 [3];
	logic signed [CW-1:0]   c_s6 [3];
	lavm_pkg::nmag_t        dnm_s6 [3];
	logic                   dsg_s6 [3];
	lavm_pkg::mag_t         cm_s7 [3];
	logic                   csg_s7 [3];
	lavm_pkg::mag_t         cor_s7;
	lavm_pkg::nmag_t        dnm_s7 [3];
	logic                   dsg_s7 [3];
	lavm_pkg::mag_t         cm_s8 [3];
	logic                   csg_s8 [3];
	lavm_pkg::blen_t        clen_s8;
	lavm_pkg::nmag_t        dnm_s8 [3];
	logic                   dsg_s8 [3];
	lavm_pkg::nmag_t        nm_s9 [2][3];
	logic                   sg_s9 [2][3];
	logic [2*NB-1:0]        sq_s10 [2][3];
	lavm_pkg::nmag_t        nm_s10 [2][3];
	logic                   sg_s10 [2][3];
	logic [SQW-1:0]         sum_s11 [2];
	lavm_pkg::nmag_t        nm_s11 [2][3];
	logic                   sg_s11 [2][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag2_c[0][i] = lavm_pkg::mag_of(MGW'(d_s1[i]));
			mag2_c[1][i] = lavm_pkg::mag_of(MGW'(up_s1[i]));
			dsv_c[i] = sgn_s4[0][i] ? -$signed({1'b0, nm_s4[0][i]}) : $signed({1'b0, nm_s4[0][i]});
			usv_c[i] = sgn_s4[1][i] ? -$signed({1'b0, nm_s4[1][i]}) : $signed({1'b0, nm_s4[1][i]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= opcode ? (WW+1)'(vec_a[i]) - (WW+1)'(pos_a[i]) : (WW+1)'(vec_a[i]);
				up_s1[i] <= (WW+1)'(up_a[i]);
			end
			for (int n = 0; n < 2; n++) begin
				or_s2[n]  <= mag2_c[n][0] | mag2_c[n][1] | mag2_c[n][2];
				len_s3[n] <= lavm_pkg::bit_len(or_s2[n]);
				for (int i = 0; i < 3; i++) begin
					mag_s2[n][i] <= mag2_c[n][i];
					sgn_s2[n][i] <= (n == 0) ? d_s1[i][WW] : up_s1[i][WW];
					mag_s3[n][i] <= mag_s2[n][i];
					sgn_s3[n][i] <= sgn_s2[n][i];
					nm_s4[n][i]  <= lavm_pkg::norm_shift(mag_s3[n][i], len_s3[n]);
					sgn_s4[n][i] <= sgn_s3[n][i];
				end
			end
			prod_s5[0] <= dsv_c[1] * usv_c[2];
			prod_s5[1] <= dsv_c[2] * usv_c[1];
			prod_s5[2] <= dsv_c[2] * usv_c[0];
			prod_s5[3] <= dsv_c[0] * usv_c[2];
			prod_s5[4] <= dsv_c[0] * usv_c[1];
			prod_s5[5] <= dsv_c[1] * usv_c[0];
			cor_s7  <= lavm_pkg::mag_of(c_s6[0]) | lavm_pkg::mag_of(c_s6[1])
				| lavm_pkg::mag_of(c_s6[2]);
			clen_s8 <= lavm_pkg::bit_len(cor_s7);
			for (int i = 0; i < 3; i++) begin
				dnm_s5[i] <= nm_s4[0][i];
				dsg_s5[i] <= sgn_s4[0][i];
				c_s6[i]   <= prod_s5[2*i] - prod_s5[2*i+1];
				dnm_s6[i] <= dnm_s5[i];
				dsg_s6[i] <= dsg_s5[i];
				cm_s7[i]  <= lavm_pkg::mag_of(c_s6[i]);
				csg_s7[i] <= c_s6[i][CW-1];
				dnm_s7[i] <= dnm_s6[i];
				dsg_s7[i] <= dsg_s6[i];
				cm_s8[i]  <= cm_s7[i];
				csg_s8[i] <= csg_s7[i];
				dnm_s8[i] <= dnm_s7[i];
				dsg_s8[i] <= dsg_s7[i];
				nm_s9[0][i] <= dnm_s8[i];
				sg_s9[0][i] <= dsg_s8[i];
				nm_s9[1][i] <= lavm_pkg::norm_shift(cm_s8[i], clen_s8);
				sg_s9[1][i] <= csg_s8[i];
			end
			for (int n = 0; n < 2; n++) begin
				sum_s11[n] <= SQW'(sq_s10[n][0]) + SQW'(sq_s10[n][1]) + SQW'(sq_s10[n][2]);
				for (int i = 0; i < 3; i++) begin
					sq_s10[n][i] <= nm_s9[n][i] * nm_s9[n][i];
					nm_s10[n][i] <= nm_s9[n][i];
					sg_s10[n][i] <= sg_s9[n][i];
					nm_s11[n][i] <= nm_s10[n][i];
					sg_s11[n][i] <= sg_s10[n][i];
				end
			end
		end
	end

	// square root, one result bit per stage
	logic [SQW-1:0]  sq_x_s [SQS][2];
	logic [RTW-1:0]  sq_root_s [SQS][2];
	logic [RMW-1:0]  sq_rem_s [SQS][2];
	lavm_pkg::nmag_t sq_nm_s [SQS][2][3];
	logic            sq_sg_s [SQS][2][3];

	for (genvar k = 0; k < SQS; k++) begin : g_sq
		logic [SQW-1:0]  xi [2];
		logic [RTW-1:0]  ri [2];
		logic [RMW-1:0]  mi [2];
		lavm_pkg::nmag_t ni [2][3];
		logic            si [2][3];
		logic [RMW-1:0]  r2 [2];
		logic [RMW-1:0]  trial [2];

		if (k == 0) begin : g_first
			assign xi = sum_s11;
			assign ri = '{default: '0};
			assign mi = '{default: '0};
			assign ni = nm_s11;
			assign si = sg_s11;
		end else begin : g_next
			assign xi = sq_x_s[k-1];
			assign ri = sq_root_s[k-1];
			assign mi = sq_rem_s[k-1];
			assign ni = sq_nm_s[k-1];
			assign si = sq_sg_s[k-1];
		end

		always_comb begin
			for (int n = 0; n < 2; n++) begin
				r2[n]    = {mi[n][RMW-3:0], xi[n][SQW-1 -: 2]};
				trial[n] = RMW'({ri[n], 2'b01});
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int n = 0; n < 2; n++) begin
					sq_x_s[k][n] <= xi[n] << 2;
					if (r2[n] >= trial[n]) begin
						sq_rem_s[k][n]  <= r2[n] - trial[n];
						sq_root_s[k][n] <= {ri[n][RTW-2:0], 1'b1};
					end else begin
						sq_rem_s[k][n]  <= r2[n];
						sq_root_s[k][n] <= {ri[n][RTW-2:0], 1'b0};
					end
					for (int i = 0; i < 3; i++) begin
						sq_nm_s[k][n][i] <= ni[n][i];
						sq_sg_s[k][n][i] <= si[n][i];
					end
				end
			end
		end
	end

	// divider operands, then one quotient bit per stage
	logic [NUMW-1:0] dp_num_s [2][3];
	logic [RTW-1:0]  dp_den_s [2];
	logic            dp_sg_s [2][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 2; n++) begin
				dp_den_s[n] <= sq_root_s[SQS-1][n];
				for (int i = 0; i < 3; i++) begin
					dp_num_s[n][i] <= (NUMW'(sq_nm_s[SQS-1][n][i]) << FB)
						+ NUMW'(sq_root_s[SQS-1][n] >> 1);
					dp_sg_s[n][i]  <= sq_sg_s[SQS-1][n][i];
				end
			end
		end
	end

	logic [DRW-1:0] dv_rem_s [QB][2][3];
	logic [QB-1:0]  dv_q_s [QB][2][3];
	logic [QB-1:0]  dv_lo_s [QB][2][3];
	logic [RTW-1:0] dv_den_s [QB][2];
	logic           dv_sg_s [QB][2][3];

	for (genvar j = 0; j < QB; j++) begin : g_dv
		logic [DRW-1:0] rmi [2][3];
		logic [QB-1:0]  qi [2][3];
		logic [QB-1:0]  loi [2][3];
		logic [RTW-1:0] dni [2];
		logic           sgi [2][3];
		logic [DRW-1:0] r [2][3];

		if (j == 0) begin : g_first
			always_comb begin
				for (int n = 0; n < 2; n++) begin
					dni[n] = dp_den_s[n];
					for (int i = 0; i < 3; i++) begin
						rmi[n][i] = DRW'(dp_num_s[n][i][NUMW-1:QB]);
						loi[n][i] = dp_num_s[n][i][QB-1:0];
						qi[n][i]  = '0;
						sgi[n][i] = dp_sg_s[n][i];
					end
				end
			end
		end else begin : g_next
			assign rmi = dv_rem_s[j-1];
			assign qi  = dv_q_s[j-1];
			assign loi = dv_lo_s[j-1];
			assign dni = dv_den_s[j-1];
			assign sgi = dv_sg_s[j-1];
		end

		always_comb begin
			for (int n = 0; n < 2; n++) begin
				for (int i = 0; i < 3; i++) begin
					r[n][i] = {rmi[n][i][DRW-2:0], loi[n][i][QB-1]};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int n = 0; n < 2; n++) begin
					dv_den_s[j][n] <= dni[n];
					for (int i = 0; i < 3; i++) begin
						dv_lo_s[j][n][i] <= loi[n][i] << 1;
						dv_sg_s[j][n][i] <= sgi[n][i];
						if (r[n][i] >= DRW'(dni[n])) begin
							dv_rem_s[j][n][i] <= r[n][i] - DRW'(dni[n]);
							dv_q_s[j][n][i]   <= {qi[n][i][QB-2:0], 1'b1};
						end else begin
							dv_rem_s[j][n][i] <= r[n][i];
							dv_q_s[j][n][i]   <= {qi[n][i][QB-2:0], 1'b0};
						end
					end
				end
			end
		end
	end

	// tail: sign, v = w x u, translations
	lavm_pkg::axis_t         ax_s61 [2][3];
	logic [QB-1:0]           qc_c [2][3];
	logic signed [VPW-1:0]   vp_s62 [6];
	lavm_pkg::axis_t         ax_s62 [2][3];
	logic signed [VPW:0]     vd_s63 [3];
	lavm_pkg::axis_t         ax_s63 [2][3];
	logic [VPW:0]            vm_c [3];
	logic [VPW:0]            vq_c [3];
	lavm_pkg::axis_t         b_s64 [3][3];
	logic signed [TPW-1:0]   tp_s65 [3][3];
	lavm_pkg::axis_t         b_s65 [3][3];
	logic signed [TSW-1:0]   ts_s66 [3];
	lavm_pkg::axis_t         b_s66 [3][3];
	logic signed [TSW:0]     rnd_c [3];
	logic signed [TSW:0]     neg_c [3];
	logic signed [WW-1:0]    tr_c [3];
	logic signed [WW-1:0]    tr_s67 [3];
	lavm_pkg::axis_t         b_s67 [3][3];

	always_comb begin
		for (int n = 0; n < 2; n++) begin
			for (int i = 0; i < 3; i++) begin
				qc_c[n][i] = dv_q_s[QB-1][n][i];
				if (qc_c[n][i] > QB'(2**FB)) qc_c[n][i] = QB'(2**FB);
			end
		end
		for (int i = 0; i < 3; i++) begin
			vm_c[i] = vd_s63[i][VPW] ? (VPW+1)'(-vd_s63[i]) : (VPW+1)'(vd_s63[i]);
			vq_c[i] = (vm_c[i] + (VPW+1)'(2**(FB-1))) >> FB;
			if (vq_c[i] > (VPW+1)'(2**FB)) vq_c[i] = (VPW+1)'(2**FB);
			rnd_c[i] = (TSW+1)'(ts_s66[i]) + (TSW+1)'(2**(FB-1));
			rnd_c[i] = rnd_c[i] >>> FB;
			neg_c[i] = -rnd_c[i];
			if (neg_c[i][TSW:WW-1] != {(TSW-WW+2){neg_c[i][TSW]}}) begin
				tr_c[i] = neg_c[i][TSW] ? $signed({1'b1, {(WW-1){1'b0}}})
					: $signed({1'b0, {(WW-1){1'b1}}});
			end else begin
				tr_c[i] = neg_c[i][WW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 2; n++) begin
				for (int i = 0; i < 3; i++) begin
					ax_s61[n][i] <= dv_sg_s[QB-1][n][i] ? -$signed(AW'(qc_c[n][i]))
						: $signed(AW'(qc_c[n][i]));
					ax_s62[n][i] <= ax_s61[n][i];
					ax_s63[n][i] <= ax_s62[n][i];
				end
			end
			vp_s62[0] <= ax_s61[0][1] * ax_s61[1][2];
			vp_s62[1] <= ax_s61[0][2] * ax_s61[1][1];
			vp_s62[2] <= ax_s61[0][2] * ax_s61[1][0];
			vp_s62[3] <= ax_s61[0][0] * ax_s61[1][2];
			vp_s62[4] <= ax_s61[0][0] * ax_s61[1][1];
			vp_s62[5] <= ax_s61[0][1] * ax_s61[1][0];
			for (int i = 0; i < 3; i++) begin
				vd_s63[i]   <= (VPW+1)'(vp_s62[2*i]) - (VPW+1)'(vp_s62[2*i+1]);
				b_s64[0][i] <= ax_s63[1][i];
				b_s64[1][i] <= vd_s63[i][VPW] ? -$signed(AW'(vq_c[i])) : $signed(AW'(vq_c[i]));
				b_s64[2][i] <= ax_s63[0][i];
			end
			for (int r = 0; r < 3; r++) begin
				ts_s66[r] <= TSW'(tp_s65[r][0]) + TSW'(tp_s65[r][1]) + TSW'(tp_s65[r][2]);
				tr_s67[r] <= tr_c[r];
				for (int i = 0; i < 3; i++) begin
					tp_s65[r][i] <= b_s64[r][i] * $signed(side_s[I_TP-1].pos[i]);
					b_s65[r][i]  <= b_s64[r][i];
					b_s66[r][i]  <= b_s65[r][i];
					b_s67[r][i]  <= b_s66[r][i];
				end
			end
		end
	end

	// item side data: position and status travel with the valid bits
	lavm_pkg::side_t side4_c;
	lavm_pkg::side_t side9_c;

	always_comb begin
		side4_c = side_s[3];
		if (len_s3[0] == '0) begin
			side4_c.status = lavm_pkg::ST_ZERO_DIR;
		end else if (len_s3[1] == '0) begin
			side4_c.status = lavm_pkg::ST_PARALLEL;
		end
		side9_c = side_s[8];
		if (side_s[8].status == lavm_pkg::ST_OK && clen_s8 == '0) begin
			side9_c.status = lavm_pkg::ST_PARALLEL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				side_s[1].pos[i] <= pos_a[i];
			end
			side_s[1].status <= lavm_pkg::ST_OK;
			for (int k = 2; k <= NST; k++) begin
				if (k == 4) begin
					side_s[k] <= side4_c;
				end else if (k == 9) begin
					side_s[k] <= side9_c;
				end else begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	// row register
	logic              out_vld_q;
	logic [1:0]        row_q;
	lavm_pkg::axis_t   ax_o_q [3][3];
	logic signed [WW-1:0] tr_o_q [3];
	lavm_pkg::status_t st_q;

	assign adv      = !vld_s[NST] || !out_vld_q || (out_ready && row_q == lavm_pkg::ROW_W);
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
			row_q     <= lavm_pkg::ROW_U;
		end else begin
			if (adv) vld_s <= {vld_s[NST-1:1], in_valid};
			if (adv && vld_s[NST]) begin
				out_vld_q <= 1'b1;
				row_q     <= lavm_pkg::ROW_U;
			end else if (out_vld_q && out_ready) begin
				if (row_q == lavm_pkg::ROW_W) begin
					out_vld_q <= 1'b0;
				end else begin
					row_q <= row_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s[NST]) begin
			st_q <= side_s[NST].status;
			for (int r = 0; r < 3; r++) begin
				tr_o_q[r] <= (side_s[NST].status == lavm_pkg::ST_OK) ? tr_s67[r] : '0;
				for (int i = 0; i < 3; i++) begin
					ax_o_q[r][i] <= (side_s[NST].status == lavm_pkg::ST_OK) ? b_s67[r][i] : '0;
				end
			end
		end
	end

	always_comb begin
		case (row_q)
			lavm_pkg::ROW_U: begin
				axis_x = ax_o_q[0][0]; axis_y = ax_o_q[0][1]; axis_z = ax_o_q[0][2];
				translation = tr_o_q[0];
			end
			lavm_pkg::ROW_V: begin
				axis_x = ax_o_q[1][0]; axis_y = ax_o_q[1][1]; axis_z = ax_o_q[1][2];
				translation = tr_o_q[1];
			end
			default: begin
				axis_x = ax_o_q[2][0]; axis_y = ax_o_q[2][1]; axis_z = ax_o_q[2][2];
				translation = tr_o_q[2];
			end
		endcase
	end

	assign out_valid = out_vld_q;
	assign row_index = row_q;
	assign status    = st_q;
	assign last_row  = (row_q == lavm_pkg::ROW_W);

endmodule

`default_nettype wire

// ===== src/lavm_chk.sv =====
// Port-level checker for look_at_view_matrix_unit, attached by bind.
// Depends on lavm_pkg.
`default_nettype none

module lavm_chk (
	input wire logic                                    clk,
	input wire logic                                    arst_n,
	input wire logic                                    out_valid,
	input wire logic                                    out_ready,
	input wire logic [1:0]                              row_index,
	input wire logic signed [lavm_pkg::AXIS_WIDTH-1:0]  axis_x,
	input wire logic signed [lavm_pkg::AXIS_WIDTH-1:0]  axis_y,
	input wire logic signed [lavm_pkg::AXIS_WIDTH-1:0]  axis_z,
	input wire logic signed [lavm_pkg::WORD_WIDTH-1:0]  translation,
	input wire logic [1:0]                              status,
	input wire logic                                    last_row
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_index) && $stable(translation))
		else $error("row changed while stalled");

	a_next_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_row |=>
			out_valid && row_index == $past(row_index) + 2'd1)
		else $error("row run broken");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (row_index != 2'd3) && (last_row == (row_index == lavm_pkg::ROW_W)))
		else $error("last row flag mismatch");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != lavm_pkg::ST_OK |->
			axis_x == '0 && axis_y == '0 && axis_z == '0 && translation == '0)
		else $error("error row not zero");

endmodule

bind look_at_view_matrix_unit lavm_chk u_lavm_chk (.*);

`default_nettype wire
